// ===== design/fpp_pkg.sv =====
`default_nettype none

package fpp_pkg;

    // number formats
    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int ANG_BITS     = 30;
    localparam int CORDIC_PRE   = 20;

    // derived pipeline sizes
    localparam int CORDIC_ITERS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
    localparam int DIV_BITS     = ANG_BITS + 1;
    localparam int ROUTE_LEN    = (CORDIC_ITERS + 1 > DIV_BITS) ? CORDIC_ITERS + 1 : DIV_BITS;
    localparam int ROOT_BITS    = 32;

    // datapath widths: cordic vector, angle accumulator, multiplier operand
    localparam int CW = 56;
    localparam int AW = 35;
    localparam int MW = 49;

    localparam logic signed [AW-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic [31:0]          FOCAL_RESET = 32'd1 << FRAC_BITS;

    // configuration register map
    typedef enum logic [2:0] {
        REG_FOCAL_X,
        REG_FOCAL_Y,
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_DIST_K1,
        REG_DIST_K2,
        REG_DIST_K3,
        REG_DIST_K4
    } cfg_reg_t;

    // point data carried alongside the root and angle units
    typedef struct packed {
        logic [31:0]        ax;
        logic [31:0]        ay;
        logic               sx;
        logic               sy;
        logic signed [31:0] z;
    } side_t;

    // partial products of one split multiply
    typedef struct packed {
        logic        neg;
        logic [47:0] p00;
        logic [47:0] p01;
        logic [47:0] p10;
        logic [47:0] p11;
    } mul_pp_t;

    // arctangent of 2^-i in Q30
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] val;
        case (idx)
            5'd0:  val = 30'd843314856;
            5'd1:  val = 30'd497837829;
            5'd2:  val = 30'd263043836;
            5'd3:  val = 30'd133525158;
            5'd4:  val = 30'd67021686;
            5'd5:  val = 30'd33543515;
            5'd6:  val = 30'd16775850;
            5'd7:  val = 30'd8388437;
            5'd8:  val = 30'd4194282;
            5'd9:  val = 30'd2097149;
            5'd10: val = 30'd1048575;
            5'd11: val = 30'd524287;
            5'd12: val = 30'd262143;
            5'd13: val = 30'd131071;
            5'd14: val = 30'd65535;
            5'd15: val = 30'd32767;
            5'd16: val = 30'd16383;
            5'd17: val = 30'd8191;
            5'd18: val = 30'd4095;
            5'd19: val = 30'd2047;
            5'd20: val = 30'd1023;
            5'd21: val = 30'd511;
            5'd22: val = 30'd255;
            5'd23: val = 30'd127;
            5'd24: val = 30'd63;
            5'd25: val = 30'd31;
            5'd26: val = 30'd15;
            5'd27: val = 30'd8;
            5'd28: val = 30'd4;
            5'd29: val = 30'd2;
            5'd30: val = 30'd1;
            default: val = 30'd0;
        endcase
        return val;
    endfunction

    // first half of a Q30 multiply: sign and four 24x24 partial products
    function automatic mul_pp_t mul_parts(input logic signed [MW-1:0] a,
                                          input logic signed [MW-1:0] b);
        logic [MW-1:0] ua;
        logic [MW-1:0] ub;
        mul_pp_t       pp;
        ua     = a[MW-1] ? MW'(-a) : a;
        ub     = b[MW-1] ? MW'(-b) : b;
        pp.neg = a[MW-1] ^ b[MW-1];
        pp.p00 = 48'(ua[23:0])  * 48'(ub[23:0]);
        pp.p01 = 48'(ua[23:0])  * 48'(ub[47:24]);
        pp.p10 = 48'(ua[47:24]) * 48'(ub[23:0]);
        pp.p11 = 48'(ua[47:24]) * 48'(ub[47:24]);
        return pp;
    endfunction

    // second half: sum, truncate toward zero, apply sign
    function automatic logic signed [63:0] mul_join(input mul_pp_t pp);
        logic [95:0] full;
        logic [63:0] q;
        full = {pp.p11, 48'd0} + {24'd0, pp.p01, 24'd0}
             + {24'd0, pp.p10, 24'd0} + {48'd0, pp.p00};
        q    = full[ANG_BITS +: 64];
        return pp.neg ? -$signed(q) : $signed(q);
    endfunction

endpackage

`default_nettype wire

// ===== design/fpp_isqrt.sv =====
`default_nettype none

module fpp_isqrt
    import fpp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         en,
    input  wire logic         in_valid,
    input  wire logic [63:0]  in_rad,
    input  wire side_t        in_side,
    output logic              out_valid,
    output logic [31:0]       out_root,
    output side_t             out_side
);

    logic [63:0] rem_reg   [0:ROOT_BITS-1];
    logic [63:0] res_reg   [0:ROOT_BITS-1];
    side_t       side_reg  [0:ROOT_BITS-1];
    logic        valid_reg [0:ROOT_BITS-1];

    // one result bit per stage, most significant first
    for (genvar s = 0; s < ROOT_BITS; s++) begin : g_step
        logic [63:0] rem_cur;
        logic [63:0] res_cur;
        logic [63:0] bit_cur;
        logic [63:0] trial;
        side_t       side_cur;
        logic        vld_cur;

        if (s == 0) begin : g_first
            assign rem_cur  = in_rad;
            assign res_cur  = '0;
            assign side_cur = in_side;
            assign vld_cur  = in_valid;
        end else begin : g_next
            assign rem_cur  = rem_reg[s-1];
            assign res_cur  = res_reg[s-1];
            assign side_cur = side_reg[s-1];
            assign vld_cur  = valid_reg[s-1];
        end

        assign bit_cur = 64'd1 << (2 * (ROOT_BITS - 1 - s));
        assign trial   = res_cur + bit_cur;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (en) begin
                valid_reg[s] <= vld_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_cur >= trial) begin
                    rem_reg[s] <= rem_cur - trial;
                    res_reg[s] <= (res_cur >> 1) + bit_cur;
                end else begin
                    rem_reg[s] <= rem_cur;
                    res_reg[s] <= res_cur >> 1;
                end
                side_reg[s] <= side_cur;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_BITS-1];
    assign out_root  = res_reg[ROOT_BITS-1][31:0];
    assign out_side  = side_reg[ROOT_BITS-1];

endmodule

`default_nettype wire

// ===== design/fpp_atan_ratio.sv =====
`default_nettype none

module fpp_atan_ratio
    import fpp_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [31:0]   in_root,
    input  wire side_t         in_side,
    output logic               out_valid,
    output logic [31:0]        out_theta,
    output logic signed [31:0] out_ratio_x,
    output logic signed [31:0] out_ratio_y,
    output logic               out_nz
);

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [AW-1:0] acc;
        logic [31:0]          remx;
        logic [31:0]          remy;
        logic [DIV_BITS-1:0]  qx;
        logic [DIV_BITS-1:0]  qy;
        logic [31:0]          root;
        logic                 sx;
        logic                 sy;
        logic                 nz;
    } stage_t;

    stage_t st_reg    [0:ROUTE_LEN-1];
    logic   valid_reg [0:ROUTE_LEN-1];

    // cordic rotation and both long divisions share one stage chain
    for (genvar j = 0; j < ROUTE_LEN; j++) begin : g_stage
        stage_t               cur;
        stage_t               nxt;
        logic                 vld;
        logic                 nbx;
        logic                 nby;
        logic signed [CW-1:0] cx_n;
        logic signed [CW-1:0] cy_n;
        logic signed [AW-1:0] acc_n;
        logic [31:0]          remx_n;
        logic [31:0]          remy_n;
        logic [DIV_BITS-1:0]  qx_n;
        logic [DIV_BITS-1:0]  qy_n;

        if (j == 0) begin : g_setup
            logic signed [CW-1:0] zw;
            logic signed [CW-1:0] rw;
            logic                 zneg;
            assign zw   = CW'(in_side.z);
            assign rw   = CW'({1'b0, in_root});
            assign zneg = in_side.z[31];
            // pre-rotate by a quarter turn for points behind the camera
            always_comb begin
                cur      = '0;
                cur.cx   = (zneg ? rw : zw) <<< CORDIC_PRE;
                cur.cy   = (zneg ? -zw : rw) <<< CORDIC_PRE;
                cur.acc  = zneg ? HALF_PI_Q30 : '0;
                cur.remx = {1'b0, in_side.ax[31:1]};
                cur.remy = {1'b0, in_side.ay[31:1]};
                cur.root = in_root;
                cur.sx   = in_side.sx;
                cur.sy   = in_side.sy;
                cur.nz   = (in_root != '0);
            end
            assign vld = in_valid;
            assign nbx = in_side.ax[0];
            assign nby = in_side.ay[0];
        end else begin : g_next
            assign cur = st_reg[j-1];
            assign vld = valid_reg[j-1];
            assign nbx = 1'b0;
            assign nby = 1'b0;
        end

        // vectoring step
        if (j >= 1 && j <= CORDIC_ITERS) begin : g_rot
            localparam int I = j - 1;
            logic signed [CW-1:0] cxs;
            logic signed [CW-1:0] cys;
            logic signed [CW-1:0] dx;
            logic signed [CW-1:0] dy;
            logic signed [AW-1:0] ang;
            logic                 up;
            assign cxs   = cur.cx;
            assign cys   = cur.cy;
            assign dx    = cys >>> I;
            assign dy    = cxs >>> I;
            assign ang   = AW'(atan_q30(5'(I)));
            assign up    = !cys[CW-1] && (cys != '0);
            assign cx_n  = up ? cxs + dx : cxs - dx;
            assign cy_n  = up ? cys - dy : cys + dy;
            assign acc_n = up ? cur.acc + ang : cur.acc - ang;
        end else begin : g_rot_hold
            assign cx_n  = cur.cx;
            assign cy_n  = cur.cy;
            assign acc_n = cur.acc;
        end

        // restoring division step, one quotient bit each
        if (j < DIV_BITS) begin : g_div
            localparam int B = DIV_BITS - 1 - j;
            logic [32:0] shx;
            logic [32:0] shy;
            logic [32:0] den;
            logic        gex;
            logic        gey;
            assign den    = {1'b0, cur.root};
            assign shx    = {cur.remx, nbx};
            assign shy    = {cur.remy, nby};
            assign gex    = (shx >= den);
            assign gey    = (shy >= den);
            assign remx_n = gex ? 32'(shx - den) : shx[31:0];
            assign remy_n = gey ? 32'(shy - den) : shy[31:0];
            always_comb begin
                qx_n    = cur.qx;
                qy_n    = cur.qy;
                qx_n[B] = gex;
                qy_n[B] = gey;
            end
        end else begin : g_div_hold
            assign remx_n = cur.remx;
            assign remy_n = cur.remy;
            assign qx_n   = cur.qx;
            assign qy_n   = cur.qy;
        end

        always_comb begin
            nxt      = cur;
            nxt.cx   = cx_n;
            nxt.cy   = cy_n;
            nxt.acc  = acc_n;
            nxt.remx = remx_n;
            nxt.remy = remy_n;
            nxt.qx   = qx_n;
            nxt.qy   = qy_n;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (en) begin
                valid_reg[j] <= vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[j] <= nxt;
            end
        end
    end

    // angle clamp at zero and signed ratios
    logic [31:0] qxw;
    logic [31:0] qyw;
    assign qxw         = 32'(st_reg[ROUTE_LEN-1].qx);
    assign qyw         = 32'(st_reg[ROUTE_LEN-1].qy);
    assign out_valid   = valid_reg[ROUTE_LEN-1];
    assign out_theta   = st_reg[ROUTE_LEN-1].acc[AW-1] ? '0 : st_reg[ROUTE_LEN-1].acc[31:0];
    assign out_ratio_x = st_reg[ROUTE_LEN-1].sx ? -$signed(qxw) : $signed(qxw);
    assign out_ratio_y = st_reg[ROUTE_LEN-1].sy ? -$signed(qyw) : $signed(qyw);
    assign out_nz      = st_reg[ROUTE_LEN-1].nz;

endmodule

`default_nettype wire

// ===== design/fisheye_point_projection.sv =====
// channel  | ports                                          | direction
// s_       | s_valid s_ready s_point_x s_point_y s_point_z  | point words in
// m_       | m_valid m_ready m_pixel_u m_pixel_v m_saturated| pixel words out
// cfg_     | cfg_valid cfg_ready cfg_index cfg_data         | register writes in
//
// one word per clock sustained while m_ready keeps the output moving; the pipeline runs through the
// front squares, the 32-stage root, the cordic / divider chain and thirteen split multiplies
// aresetn is synchronous; it clears valid bits and restores the register defaults
// the whole pipeline holds while the output word waits, so s_ready = !m_valid || m_ready
// cfg_ready is always high

`default_nettype none

module fisheye_point_projection
    import fpp_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic signed [31:0]  s_point_x,
    input  wire logic signed [31:0]  s_point_y,
    input  wire logic signed [31:0]  s_point_z,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [31:0]       m_pixel_u,
    output logic signed [31:0]       m_pixel_v,
    output logic                     m_saturated,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);

    localparam int TAIL_LEN = 17;
    localparam int CR_LEN   = 15;
    localparam int TH_LEN   = 5;
    localparam int T2_LEN   = 7;
    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic               nz;
    } carry_t;

    logic en;

    // configuration registers
    logic [31:0] focal_x_reg;
    logic [31:0] focal_y_reg;
    logic [31:0] center_x_reg;
    logic [31:0] center_y_reg;
    logic [31:0] dist_k1_reg;
    logic [31:0] dist_k2_reg;
    logic [31:0] dist_k3_reg;
    logic [31:0] dist_k4_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg  <= FOCAL_RESET;
            focal_y_reg  <= FOCAL_RESET;
            center_x_reg <= '0;
            center_y_reg <= '0;
            dist_k1_reg  <= '0;
            dist_k2_reg  <= '0;
            dist_k3_reg  <= '0;
            dist_k4_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_FOCAL_X:  focal_x_reg  <= cfg_data;
                REG_FOCAL_Y:  focal_y_reg  <= cfg_data;
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                REG_DIST_K1:  dist_k1_reg  <= cfg_data;
                REG_DIST_K2:  dist_k2_reg  <= cfg_data;
                REG_DIST_K3:  dist_k3_reg  <= cfg_data;
                REG_DIST_K4:  dist_k4_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // global stall: everything moves when the output word can move
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // front: magnitudes, squares, sum of squares
    side_t       p1_side_reg;
    side_t       p2_side_reg;
    side_t       p3_side_reg;
    logic [63:0] sqx_reg;
    logic [63:0] sqy_reg;
    logic [63:0] rad_reg;
    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;
    side_t       side_next;

    always_comb begin
        side_next.ax = s_point_x[31] ? 32'(-s_point_x) : s_point_x;
        side_next.ay = s_point_y[31] ? 32'(-s_point_y) : s_point_y;
        side_next.sx = s_point_x[31];
        side_next.sy = s_point_y[31];
        side_next.z  = s_point_z;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_side_reg <= side_next;
            sqx_reg     <= 64'(p1_side_reg.ax) * 64'(p1_side_reg.ax);
            sqy_reg     <= 64'(p1_side_reg.ay) * 64'(p1_side_reg.ay);
            p2_side_reg <= p1_side_reg;
            rad_reg     <= sqx_reg + sqy_reg;
            p3_side_reg <= p2_side_reg;
        end
    end

    // radius
    logic        rt_valid;
    logic [31:0] rt_root;
    side_t       rt_side;

    fpp_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_rad    (rad_reg),
        .in_side   (p3_side_reg),
        .out_valid (rt_valid),
        .out_root  (rt_root),
        .out_side  (rt_side)
    );

    // incidence angle and x/r, y/r
    logic               ar_valid;
    logic [31:0]        ar_theta;
    logic signed [31:0] ar_rx;
    logic signed [31:0] ar_ry;
    logic               ar_nz;

    fpp_atan_ratio u_atan_ratio (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (rt_valid),
        .in_root     (rt_root),
        .in_side     (rt_side),
        .out_valid   (ar_valid),
        .out_theta   (ar_theta),
        .out_ratio_x (ar_rx),
        .out_ratio_y (ar_ry),
        .out_nz      (ar_nz)
    );

    // tail: odd powers, polynomial, ratio, focal length
    logic               vt_reg [0:TAIL_LEN-1];
    carry_t             cr_reg [0:CR_LEN-1];
    logic [31:0]        th_reg [0:TH_LEN-1];
    logic signed [63:0] t2_reg [0:T2_LEN-1];
    mul_pp_t            pp2_reg, pp3_reg, pp5_reg, pp7_reg, pp9_reg;
    mul_pp_t            pk1_reg, pk2_reg, pk3_reg, pk4_reg;
    mul_pp_t            ppx_reg, ppy_reg, ppu_reg, ppv_reg;
    logic signed [63:0] t3_reg, t5_reg, t7_reg, t9_reg;
    logic signed [63:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [63:0] acc5_reg, acc6_reg, acc7_reg, acc8_reg;
    logic signed [63:0] acc9_reg, acc10_reg, acc11_reg, td_reg;
    logic signed [63:0] mx_reg, my_reg, ux_reg, uy_reg;
    logic signed [MW-1:0] mxm;
    logic signed [MW-1:0] mym;

    assign mxm = cr_reg[CR_LEN-1].nz ? MW'(mx_reg) : '0;
    assign mym = cr_reg[CR_LEN-1].nz ? MW'(my_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TAIL_LEN; i++) begin
                vt_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vt_reg[0] <= ar_valid;
            for (int i = 1; i < TAIL_LEN; i++) begin
                vt_reg[i] <= vt_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // delay lines
            cr_reg[0] <= '{rx: ar_rx, ry: ar_ry, nz: ar_nz};
            for (int i = 1; i < CR_LEN; i++) begin
                cr_reg[i] <= cr_reg[i-1];
            end
            th_reg[0] <= ar_theta;
            for (int i = 1; i < TH_LEN; i++) begin
                th_reg[i] <= th_reg[i-1];
            end
            t2_reg[0] <= mul_join(pp2_reg);
            for (int i = 1; i < T2_LEN; i++) begin
                t2_reg[i] <= t2_reg[i-1];
            end
            // theta squared, cubed
            pp2_reg <= mul_parts(MW'({1'b0, ar_theta}), MW'({1'b0, ar_theta}));
            pp3_reg <= mul_parts(MW'(t2_reg[0]), MW'({1'b0, th_reg[1]}));
            t3_reg  <= mul_join(pp3_reg);
            // fifth power and k1 term
            pp5_reg  <= mul_parts(MW'(t3_reg), MW'(t2_reg[2]));
            pk1_reg  <= mul_parts(MW'($signed(dist_k1_reg)), MW'(t3_reg));
            t5_reg   <= mul_join(pp5_reg);
            p1_reg   <= mul_join(pk1_reg);
            acc5_reg <= 64'({1'b0, th_reg[TH_LEN-1]});
            // seventh power and k2 term
            pp7_reg  <= mul_parts(MW'(t5_reg), MW'(t2_reg[4]));
            pk2_reg  <= mul_parts(MW'($signed(dist_k2_reg)), MW'(t5_reg));
            acc6_reg <= acc5_reg + p1_reg;
            t7_reg   <= mul_join(pp7_reg);
            p2_reg   <= mul_join(pk2_reg);
            acc7_reg <= acc6_reg;
            // ninth power and k3 term
            pp9_reg  <= mul_parts(MW'(t7_reg), MW'(t2_reg[6]));
            pk3_reg  <= mul_parts(MW'($signed(dist_k3_reg)), MW'(t7_reg));
            acc8_reg <= acc7_reg + p2_reg;
            t9_reg   <= mul_join(pp9_reg);
            p3_reg   <= mul_join(pk3_reg);
            acc9_reg <= acc8_reg;
            // k4 term and distorted angle
            pk4_reg   <= mul_parts(MW'($signed(dist_k4_reg)), MW'(t9_reg));
            acc10_reg <= acc9_reg + p3_reg;
            p4_reg    <= mul_join(pk4_reg);
            acc11_reg <= acc10_reg;
            td_reg    <= acc11_reg + p4_reg;
            // direction ratios
            ppx_reg <= mul_parts(MW'(cr_reg[12].rx), MW'(td_reg));
            ppy_reg <= mul_parts(MW'(cr_reg[12].ry), MW'(td_reg));
            mx_reg  <= mul_join(ppx_reg);
            my_reg  <= mul_join(ppy_reg);
            // focal lengths, zero radius gives the principal point
            ppu_reg <= mul_parts(MW'({1'b0, focal_x_reg}), mxm);
            ppv_reg <= mul_parts(MW'({1'b0, focal_y_reg}), mym);
            ux_reg  <= mul_join(ppu_reg);
            uy_reg  <= mul_join(ppv_reg);
        end
    end

    // offset and clamp into the output register
    logic signed [63:0] su;
    logic signed [63:0] sv;
    logic signed [31:0] pixel_u_next;
    logic signed [31:0] pixel_v_next;
    logic               sat_next;
    logic signed [31:0] pixel_u_reg;
    logic signed [31:0] pixel_v_reg;
    logic               sat_reg;

    always_comb begin
        su = ux_reg + 64'($signed(center_x_reg));
        sv = uy_reg + 64'($signed(center_y_reg));
        sat_next = 1'b0;
        if (su > S32_MAX) begin
            pixel_u_next = S32_MAX[31:0];
            sat_next     = 1'b1;
        end else if (su < S32_MIN) begin
            pixel_u_next = S32_MIN[31:0];
            sat_next     = 1'b1;
        end else begin
            pixel_u_next = su[31:0];
        end
        if (sv > S32_MAX) begin
            pixel_v_next = S32_MAX[31:0];
            sat_next     = 1'b1;
        end else if (sv < S32_MIN) begin
            pixel_v_next = S32_MIN[31:0];
            sat_next     = 1'b1;
        end else begin
            pixel_v_next = sv[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vt_reg[TAIL_LEN-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pixel_u_reg <= pixel_u_next;
            pixel_v_reg <= pixel_v_next;
            sat_reg     <= sat_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pixel_u   = pixel_u_reg;
    assign m_pixel_v   = pixel_v_reg;
    assign m_saturated = sat_reg;

endmodule

`default_nettype wire

// ===== design/fpp_checker.sv =====
`default_nettype none

module fpp_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [31:0] m_pixel_u,
    input wire logic signed [31:0] m_pixel_v,
    input wire logic               m_saturated
);

    // a waiting output word stays
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("output word dropped while stalled");

    // and keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_pixel_u) && $stable(m_pixel_v) && $stable(m_saturated))
        else $error("output payload changed while stalled");

    // a stalled output word stalls the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while pipeline is stalled");

    // a flagged word carries a clipped coordinate
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |->
            m_pixel_u == 32'sh7fffffff || m_pixel_u == 32'sh80000000 ||
            m_pixel_v == 32'sh7fffffff || m_pixel_v == 32'sh80000000)
        else $error("saturation flag without a clipped coordinate");

endmodule

bind fisheye_point_projection fpp_checker u_fpp_checker (.*);

`default_nettype wire
